### design/mcte_pkg.sv
// mcte_pkg: shared constants and types for the MIDI clock tempo estimator.
// No dependencies; used by the core, the port checker, the tempo checker and the testbench.
`timescale 1ns / 1ps

package mcte_pkg;

    localparam int STATUS_W     = 8;
    localparam int TIME_W       = 48;
    localparam int TEMPO_W      = 18;
    localparam int KEEP_W       = 8;
    localparam int ACC_W        = 27;   // k*prev + (256-k)*raw + 128 < 2^26
    localparam int CNT_W        = 6;
    localparam int WIN_W        = 9;    // keep weight and its complement, 0..256
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 24;

    localparam int SPAN_DEFAULT = 24;

    localparam logic [STATUS_W-1:0] CLOCK_BYTE = 8'hF8;
    localparam logic [STATUS_W-1:0] START_BYTE = 8'hFA;
    localparam logic [KEEP_W-1:0]   KEEP_RESET = 8'd243;
    localparam logic [TEMPO_W-1:0]  TEMPO_MAX  = 18'h3FFFF;
    localparam logic [ACC_W-1:0]    ROUND_HALF = 27'd128;
    localparam logic [63:0]         SCALE_Q8   = 64'd640000000000;

    localparam logic [CNT_W-1:0]    DIV_STEPS  = 6'd48;
    localparam logic [CNT_W-1:0]    MUL_STEPS  = 6'd9;

    localparam logic [0:0] KIND_TEMPO = 1'b0;
    localparam logic [0:0] KIND_TAP   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_DIV,
        S_SEED,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

endpackage

### design/midi_clock_tempo_estimator_core.sv
// midi_clock_tempo_estimator_core: top level of the MIDI clock tempo estimator.
// Depends on mcte_pkg and mcte_ram (timestamp ring).
//
// Feed it MIDI real-time bytes with their nanosecond arrival stamps on the
// slave stream; tempo updates and start taps come out on the master stream.
// A clock byte (0xF8) is stored in a ring of SPAN stamps; the first SPAN clock
// bytes only fill the ring. From then on every clock byte yields one tempo
// update: the time spanned by the last SPAN intervals is turned into bpm in
// unsigned Q10.8 (rounded, saturated at 262143, zero span saturates), then
// exponentially smoothed with keep weight k/256 on the old value (the first
// estimate, or any while the smoothed value is zero, seeds it directly).
// A start byte (0xFA) gives a tap result (tuser=1, tempo 0); other bytes are
// dropped without a result. One transaction is worked on at a time: a clock
// byte is read from the ring, goes through the 48-step bit-serial restoring
// divider and a 9-step shift-add smoothing multiplier, and its result is then
// loaded into the output register; a zero span skips the divider. A warm-up
// clock byte only writes the ring before the input is free again, a tap goes
// straight to the output step, and an ignored byte leaves the input ready. An
// output stall holds the block in its last step until the output register is
// free. The output register lets the next transaction be accepted while a
// result still waits to be taken. Write keep_weight only while idle. The ring
// needs no clearing pass after reset.
`timescale 1ns / 1ps

module midi_clock_tempo_estimator_core #(
    parameter int SPAN = mcte_pkg::SPAN_DEFAULT   // 1..96 clock bytes per estimate
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [mcte_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,   // [7:0] status_byte, [55:8] time_ns
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [mcte_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,   // [17:0] tempo_q8, [23:18] zero
    output logic [0:0]                         o_m_axis_tuser,   // [0] kind
    // keep_weight register
    input  logic                               i_cfg_we,
    input  logic [mcte_pkg::KEEP_W-1:0]        i_cfg_wdata
);

    localparam int IDX_W = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int TW    = mcte_pkg::TIME_W;
    localparam int QW    = mcte_pkg::TEMPO_W;
    localparam int AW    = mcte_pkg::ACC_W;
    localparam int WW    = mcte_pkg::WIN_W;
    // numerator base: 640e9 * SPAN, below 2^46 across the SPAN range
    localparam logic [TW-1:0]    NUM_BASE = TW'(mcte_pkg::SCALE_Q8 * 64'(SPAN));
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SPAN - 1);

    mcte_pkg::t_state r_state, n_state;

    // input fields
    logic [mcte_pkg::STATUS_W-1:0] in_status;
    logic [TW-1:0]                 in_time;
    assign in_status = i_s_axis_tdata[mcte_pkg::STATUS_W-1:0];
    assign in_time   = i_s_axis_tdata[mcte_pkg::STATUS_W +: TW];

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // control state
    logic [IDX_W-1:0]             r_widx;
    logic                         r_filled;
    logic [QW-1:0]                r_smooth;
    logic [mcte_pkg::KEEP_W-1:0]  r_keep;
    logic                         r_ovalid;

    // work registers
    logic [TW-1:0]                r_now;
    logic [TW-1:0]                r_num;      // dividend, shifted out MSB first
    logic [TW-1:0]                r_den;
    logic [TW-1:0]                r_rem;
    logic [QW-1:0]                r_q;
    logic                         r_ovf;      // quotient bit lost above Q10.8 range
    logic [mcte_pkg::CNT_W-1:0]   r_cnt;
    logic [QW-1:0]                r_raw;
    logic [QW-1:0]                r_prev;
    logic [WW-1:0]                r_kbits;    // keep weight, consumed MSB first
    logic [WW-1:0]                r_wbits;    // 256 - keep weight
    logic [AW-1:0]                r_acc;
    logic [0:0]                   r_rkind;
    logic [QW-1:0]                r_rtempo;
    logic [0:0]                   r_okind;
    logic [QW-1:0]                r_otempo;

    // ring access
    logic          ram_we, ram_re;
    logic [TW-1:0] ram_rdata;

    mcte_ram #(
        .WIDTH (TW),
        .DEPTH (SPAN),
        .ADDR_W(IDX_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_widx),
        .i_wdata(r_now),
        .i_re   (ram_re),
        .i_raddr(r_widx),
        .o_rdata(ram_rdata)
    );

    // datapath terms
    logic [TW-1:0] span_ns;
    logic          span_zero;
    assign span_ns   = r_now - ram_rdata;     // wraps modulo 2^48
    assign span_zero = (span_ns == '0);

    // one restoring-division step
    logic [TW:0] rem_sh, rem_diff;
    logic        rem_ge;
    assign rem_sh   = {r_rem, r_num[TW-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});

    // seed for smoothing
    logic [QW-1:0] raw_sat, prev_sel;
    assign raw_sat  = (r_ovf || r_q > mcte_pkg::TEMPO_MAX) ? mcte_pkg::TEMPO_MAX : r_q;
    assign prev_sel = (r_smooth == '0) ? raw_sat : r_smooth;

    // one Horner step of k*prev + (256-k)*raw
    logic [AW-1:0] acc_step, acc_round;
    assign acc_step  = {r_acc[AW-2:0], 1'b0}
                     + (r_kbits[WW-1] ? AW'(r_prev) : '0)
                     + (r_wbits[WW-1] ? AW'(r_raw)  : '0);
    assign acc_round = r_acc + mcte_pkg::ROUND_HALF;

    logic out_free;
    assign out_free = !r_ovalid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcte_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (in_status == mcte_pkg::CLOCK_BYTE) begin
                        n_state = mcte_pkg::S_SPAN;
                    end else if (in_status == mcte_pkg::START_BYTE) begin
                        n_state = mcte_pkg::S_OUT;
                    end
                end
            end
            mcte_pkg::S_SPAN: begin
                if (!r_filled) begin
                    n_state = mcte_pkg::S_IDLE;       // warm-up: fill only
                end else if (span_zero) begin
                    n_state = mcte_pkg::S_SEED;
                end else begin
                    n_state = mcte_pkg::S_DIV;
                end
            end
            mcte_pkg::S_DIV: begin
                if (r_cnt == '0) n_state = mcte_pkg::S_SEED;
            end
            mcte_pkg::S_SEED: n_state = mcte_pkg::S_MUL;
            mcte_pkg::S_MUL: begin
                if (r_cnt == '0) n_state = mcte_pkg::S_FIN;
            end
            mcte_pkg::S_FIN: n_state = mcte_pkg::S_OUT;
            mcte_pkg::S_OUT: begin
                if (out_free) n_state = mcte_pkg::S_IDLE;
            end
            default: n_state = mcte_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = (r_state == mcte_pkg::S_IDLE);
        ram_re          = s_acc && (in_status == mcte_pkg::CLOCK_BYTE);
        ram_we          = (r_state == mcte_pkg::S_SPAN);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mcte_pkg::S_IDLE;
            r_widx   <= '0;
            r_filled <= 1'b0;
            r_smooth <= '0;
            r_keep   <= mcte_pkg::KEEP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_keep <= i_cfg_wdata;
            end
            if (r_state == mcte_pkg::S_SPAN) begin
                if (r_widx == IDX_LAST) begin
                    r_widx   <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_widx <= r_widx + 1'b1;
                end
            end
            if (r_state == mcte_pkg::S_FIN) begin
                r_smooth <= acc_round[AW-2 -: QW];
            end
            if (r_state == mcte_pkg::S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mcte_pkg::S_IDLE: begin
                r_now    <= in_time;
                r_rkind  <= mcte_pkg::KIND_TAP;
                r_rtempo <= '0;
            end
            mcte_pkg::S_SPAN: begin
                r_num <= NUM_BASE + (span_ns >> 1);
                r_den <= span_ns;
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= span_zero;
                r_cnt <= mcte_pkg::DIV_STEPS - 1'b1;
            end
            mcte_pkg::S_DIV: begin
                r_rem <= rem_ge ? rem_diff[TW-1:0] : rem_sh[TW-1:0];
                r_num <= {r_num[TW-2:0], 1'b0};
                r_q   <= {r_q[QW-2:0], rem_ge};
                r_ovf <= r_ovf | r_q[QW-1];
                r_cnt <= r_cnt - 1'b1;
            end
            mcte_pkg::S_SEED: begin
                r_raw   <= raw_sat;
                r_prev  <= prev_sel;
                r_kbits <= {1'b0, r_keep};
                r_wbits <= WW'(9'd256 - {1'b0, r_keep});
                r_acc   <= '0;
                r_cnt   <= mcte_pkg::MUL_STEPS - 1'b1;
            end
            mcte_pkg::S_MUL: begin
                r_acc   <= acc_step;
                r_kbits <= {r_kbits[WW-2:0], 1'b0};
                r_wbits <= {r_wbits[WW-2:0], 1'b0};
                r_cnt   <= r_cnt - 1'b1;
            end
            mcte_pkg::S_FIN: begin
                r_rkind  <= mcte_pkg::KIND_TEMPO;
                r_rtempo <= acc_round[AW-2 -: QW];
            end
            mcte_pkg::S_OUT: begin
                if (out_free) begin
                    r_okind  <= r_rkind;
                    r_otempo <= r_rtempo;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tdata  = {{(mcte_pkg::OUT_TDATA_W - QW){1'b0}}, r_otempo};

endmodule

### design/mcte_ram.sv
// mcte_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; instanced by the core for the timestamp ring.
`timescale 1ns / 1ps

module mcte_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 24,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mcte_chk.sv
// mcte_chk: port-level checker for the MIDI clock tempo estimator core.
// Depends on mcte_pkg; bound to midi_clock_tempo_estimator_core below.
`timescale 1ns / 1ps

module mcte_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [mcte_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [mcte_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [0:0]                        o_m_axis_tuser
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before transaction");

    // one transaction at a time: a clock or start byte closes the input side
    // next cycle; an ignored byte leaves it open
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
        (i_s_axis_tdata[mcte_pkg::STATUS_W-1:0] == mcte_pkg::CLOCK_BYTE ||
         i_s_axis_tdata[mcte_pkg::STATUS_W-1:0] == mcte_pkg::START_BYTE)
        |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    // a tap carries a zero tempo
    a_tap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == mcte_pkg::KIND_TAP |->
        o_m_axis_tdata == '0)
        else $error("tap with nonzero tempo");

    // a start byte gives a tap after the output step when the output stays free
    a_start_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready &&
        i_s_axis_tdata[mcte_pkg::STATUS_W-1:0] == mcte_pkg::START_BYTE &&
        (!o_m_axis_tvalid || i_m_axis_tready) ##1 (!o_m_axis_tvalid || i_m_axis_tready)
        |=> o_m_axis_tvalid && o_m_axis_tuser == mcte_pkg::KIND_TAP)
        else $error("start byte produced no tap");

    // padding above the tempo stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[mcte_pkg::OUT_TDATA_W-1:mcte_pkg::TEMPO_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind midi_clock_tempo_estimator_core mcte_chk u_mcte_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .i_s_axis_tdata (i_s_axis_tdata),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

### tb/mcte_tempo_checker.sv
// mcte_tempo_checker: watches the stream ports of the tempo estimator core and
// predicts its tempo updates and start taps, then compares them against the master stream.
// Depends on mcte_pkg.
`timescale 1ns / 1ps

module mcte_tempo_checker
    import mcte_pkg::*;
#(
    parameter int SPAN = SPAN_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [0:0]             i_m_tuser,
    input  logic                   i_cfg_we,
    input  logic [KEEP_W-1:0]      i_cfg_wdata,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic [0:0]         kind;
        logic [TEMPO_W-1:0] tempo;
    } t_tempo_result;

    t_tempo_result     pending_results[$];

    // shadow of the core state
    logic [TIME_W-1:0]  clock_stamps [SPAN];
    int unsigned        next_slot;
    logic               stamps_full;
    logic [TEMPO_W-1:0] smoothed_bpm;
    logic [KEEP_W-1:0]  keep_weight;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t ns: %s", $time, msg);
        o_errors++;
    endtask

    // Q10.8 bpm from the span of SPAN clock intervals, rounded, saturated
    function automatic logic [TEMPO_W-1:0] bpm_from_span(input logic [TIME_W-1:0] span_ns);
        logic [63:0] scaled;
        logic [63:0] quot;
        if (span_ns == '0)
            return TEMPO_MAX;
        scaled = SCALE_Q8 * 64'(SPAN);
        quot   = (scaled + 64'(span_ns >> 1)) / 64'(span_ns);
        if (quot > 64'(TEMPO_MAX))
            quot = 64'(TEMPO_MAX);
        return quot[TEMPO_W-1:0];
    endfunction

    task automatic predict_status(input logic [IN_TDATA_W-1:0] beat);
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   now_ns;
        logic [TIME_W-1:0]   oldest_ns;
        logic                was_full;
        logic [TEMPO_W-1:0]  raw_bpm;
        logic [TEMPO_W-1:0]  prev_bpm;
        logic [63:0]         blend;
        t_tempo_result       res;
        status = beat[STATUS_W-1:0];
        now_ns = beat[STATUS_W +: TIME_W];
        if (status == START_BYTE) begin
            res.kind  = KIND_TAP;
            res.tempo = '0;
            pending_results.push_back(res);
        end else if (status == CLOCK_BYTE) begin
            oldest_ns               = clock_stamps[next_slot];
            was_full                = stamps_full;
            clock_stamps[next_slot] = now_ns;
            if (next_slot == SPAN - 1) begin
                next_slot   = 0;
                stamps_full = 1'b1;
            end else begin
                next_slot++;
            end
            if (was_full) begin
                raw_bpm  = bpm_from_span(now_ns - oldest_ns);
                prev_bpm = (smoothed_bpm == '0) ? raw_bpm : smoothed_bpm;
                blend    = 64'(keep_weight) * 64'(prev_bpm)
                         + (64'd256 - 64'(keep_weight)) * 64'(raw_bpm) + 64'd128;
                smoothed_bpm = blend[8 +: TEMPO_W];
                res.kind     = KIND_TEMPO;
                res.tempo    = smoothed_bpm;
                pending_results.push_back(res);
            end
        end
    endtask

    task automatic check_result();
        t_tempo_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result tuser=%0d tdata=%h",
                                      i_m_tuser, i_m_tdata));
        end else begin
            want = pending_results.pop_front();
            if (i_m_tuser !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", i_m_tuser, want.kind));
            if (i_m_tdata !== {{(OUT_TDATA_W-TEMPO_W){1'b0}}, want.tempo})
                report_mismatch($sformatf("tdata %h, expected tempo %0d",
                                          i_m_tdata, want.tempo));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            next_slot    = 0;
            stamps_full  = 1'b0;
            smoothed_bpm = '0;
            keep_weight  = KEEP_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_we)
                keep_weight = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                predict_status(i_s_tdata);
            if (i_m_tvalid && i_m_tready)
                check_result();
        end
        o_pending = pending_results.size();
    end

endmodule

### tb/tb_midi_clock_tempo_estimator_core.sv
// tb_midi_clock_tempo_estimator_core: stimulus and verdict for the MIDI clock
// tempo estimator core. Depends on mcte_pkg, the core and mcte_tempo_checker.
`timescale 1ns / 1ps

module tb_midi_clock_tempo_estimator_core;
    import mcte_pkg::*;

    localparam int SPAN           = SPAN_DEFAULT;
    // No-transaction cycles before the run is declared hung. A clock byte
    // needs its full processing, a drain before a register write adds SETTLE_CYCLES,
    // and the sink stall runs are geometric at worst 59 %; this is far beyond.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles after the last expected result: covers a clock byte's full
    // latency, so a stray late result or a dropped byte still in flight shows.
    localparam int SETTLE_CYCLES  = 80;
    // 3 phases x 3 chunks; with the dropped bytes in between ~ 650 transactions
    localparam int ITEMS_PER_CHUNK = 60;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we;
    logic [KEEP_W-1:0]      cfg_wdata;

    int errors;
    int pending;
    int idle_cycles   = 0;
    int src_idle_pct  = 0;   // chance per slot that the source holds tvalid low
    int sink_idle_pct = 0;   // chance per cycle that the sink drops tready

    logic [TIME_W-1:0] stamp_ns;   // running timestamp of the clock byte stream
    int unsigned       beat_ns;    // nominal clock interval of the current chunk

    // keep_weight plan for the random chunks: reset value, both extremes,
    // a few in between; the last chunk draws a random one
    logic [KEEP_W-1:0] keep_plan [8] = '{8'd243, 8'd255, 8'd0, 8'd1,
                                         8'd128, 8'd200, 8'd16, 8'd254};

    midi_clock_tempo_estimator_core #(
        .SPAN (SPAN)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    mcte_tempo_checker #(
        .SPAN (SPAN)
    ) tempo_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sink: tready changes on the falling edge only, stalls at sink_idle_pct.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: any transaction on either stream or a register write counts
    // as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one status byte with its stamp and hold it until accepted.
    // Entered and left on a falling edge; tvalid stays high between
    // back-to-back transactions, so it is never dropped and raised in one step.
    task automatic send_status(input logic [STATUS_W-1:0] status,
                               input logic [TIME_W-1:0] at_ns);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {at_ns, status};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // keep_weight may only change while the core is idle: stop the source,
    // wait for every expected result, then let a full clock-byte latency
    // pass in case a warm-up clock byte, which gives no result, is still worked on.
    task automatic write_keep(input logic [KEEP_W-1:0] weight);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = weight;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // Next clock stamp: mostly a steady beat with ~1 % jitter, sometimes very
    // fast beats (saturating tempo), repeated stamps, long gaps, and rarely a
    // jump to an arbitrary time (wraps the 48-bit counter, huge spans).
    task automatic advance_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            stamp_ns = stamp_ns + TIME_W'($urandom_range(beat_ns / 100 * 101,
                                                         beat_ns / 100 * 99));
        else if (pick < 82)
            stamp_ns = stamp_ns + TIME_W'($urandom_range(3_000_000, 0));
        else if (pick < 88)
            stamp_ns = stamp_ns;
        else if (pick < 99)
            stamp_ns = stamp_ns + TIME_W'($urandom);
        else
            stamp_ns = TIME_W'({$urandom, $urandom});
    endtask

    // Random traffic: counted transactions are clock and start bytes;
    // the dropped bytes in between are extra noise.
    task automatic run_traffic(input int count);
        int          sent;
        int unsigned pick;
        sent    = 0;
        beat_ns = $urandom_range(40_000_000, 2_000_000);
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                advance_stamp();
                send_status(CLOCK_BYTE, stamp_ns);
                sent++;
            end else if (pick < 88) begin
                send_status(START_BYTE, TIME_W'({$urandom, $urandom}));
                sent++;
            end else begin
                // any byte; a clock or start drawn here is handled by the checker
                send_status(STATUS_W'($urandom), TIME_W'({$urandom, $urandom}));
            end
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        stamp_ns  = TIME_W'(48'hFFFF_FFFF_FF00);
        beat_ns   = 20_833_333;   // 120 bpm

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part --------------------------------------------------
        src_idle_pct  = 16;
        sink_idle_pct = 59;

        // keep 0: smoothed value follows the raw estimate exactly
        write_keep(8'd0);

        // dropped bytes and taps at both ends of the stamp range
        send_status(8'h00, '0);
        send_status(8'hFF, '1);
        send_status(START_BYTE, '1);
        send_status(8'hF9, TIME_W'(48'h5555_5555_5555));
        send_status(START_BYTE, '0);

        // warm-up: fill the ring at one stamp just below the wrap, no results
        repeat (SPAN) send_status(CLOCK_BYTE, stamp_ns);
        // same stamp again: zero span, tempo saturates and seeds
        send_status(CLOCK_BYTE, stamp_ns);
        // half the counter range later: raw tempo rounds to zero, smoothed goes to 0
        send_status(CLOCK_BYTE, stamp_ns + TIME_W'(48'h8000_0000_0000));
        // stamp wraps past 2^48; span 0.5 s gives 120 bpm and reseeds from zero
        send_status(CLOCK_BYTE, stamp_ns + TIME_W'(500_000_000));
        stamp_ns = stamp_ns + TIME_W'(500_000_000);

        // keep 255: heaviest smoothing on a steady beat
        write_keep(8'd255);
        repeat (3) begin
            stamp_ns = stamp_ns + TIME_W'(beat_ns);
            send_status(CLOCK_BYTE, stamp_ns);
        end

        // ---- random part: three idle phases, three keep settings each -------
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 16;
                    sink_idle_pct = 59;
                end
                1: begin
                    src_idle_pct  = 59;
                    sink_idle_pct = 16;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                if (phase * 3 + chunk < 8)
                    write_keep(keep_plan[phase * 3 + chunk]);
                else
                    write_keep(KEEP_W'($urandom_range(255)));
                run_traffic(ITEMS_PER_CHUNK);
            end
        end

        // ---- drain and verdict ----------------------------------------------
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
design/mcte_pkg.sv
design/mcte_ram.sv
design/midi_clock_tempo_estimator_core.sv
design/mcte_chk.sv
tb/mcte_tempo_checker.sv
tb/tb_midi_clock_tempo_estimator_core.sv
